>>> rtl/core/smp_pkg.sv
// Shared types, register codes and constants for the synchronized move planner.
package smp_pkg;

    typedef struct packed {
        logic signed [15:0] slide_frac;
        logic signed [15:0] pan_frac;
        logic signed [15:0] tilt_frac;
    } smp_in_t;

    typedef struct packed {
        logic signed [23:0] slide_target;
        logic signed [23:0] pan_target;
        logic signed [23:0] tilt_target;
        logic [15:0]        slide_speed;
        logic [15:0]        pan_speed;
        logic [15:0]        tilt_speed;
        logic [16:0]        slide_accel;
        logic [16:0]        pan_accel;
        logic [16:0]        tilt_accel;
        logic               move_changed;
    } smp_out_t;

    // Sequencer to lane commands
    typedef struct packed {
        logic go_time;
        logic go_sync;
    } lane_ctl_t;

    // Lane to sequencer status
    typedef struct packed {
        logic        done;
        logic [31:0] move_time;
        logic [15:0] speed;
        logic [16:0] accel;
    } lane_sts_t;

    localparam int NUM_AXES = 3;

    localparam logic [2:0] REG_SPEED_FRAC  = 3'd0;
    localparam logic [2:0] REG_ACCEL_FRAC  = 3'd1;
    localparam logic [2:0] REG_SLIDE_MIN   = 3'd2;
    localparam logic [2:0] REG_SLIDE_MAX   = 3'd3;
    localparam logic [2:0] REG_PAN_CENTER  = 3'd4;
    localparam logic [2:0] REG_TILT_CENTER = 3'd5;

    localparam logic [15:0] SPEED_MAX = 16'hFFFF;
    localparam logic [16:0] ACCEL_MAX = 17'h1FFFF;
    localparam logic [31:0] TIME_MAX  = 32'hFFFFFFFF;

    // Q16.16 slide steps per mm
    localparam logic [63:0] SLIDE_K = 64'd741716;

    // Reciprocals ceil(2^k/d), exact floor division over the operand range
    localparam logic [63:0] RECIP_PAN       = (64'd1 << 38) / 64'd1088 + 64'd1;
    localparam logic [63:0] RECIP_TILT      = (64'd1 << 40) / 64'd24192 + 64'd1;
    localparam logic [63:0] RECIP_SPD_PAN   = (64'd1 << 42) / 64'd8704 + 64'd1;
    localparam logic [63:0] RECIP_SPD_TILT  = (64'd1 << 42) / 64'd24192 + 64'd1;
    localparam logic [63:0] RECIP_ACC_PAN   = (64'd1 << 44) / 64'd8704 + 64'd1;
    localparam logic [63:0] RECIP_ACC_TILT  = (64'd1 << 44) / 64'd24192 + 64'd1;

    function automatic logic [23:0] sat24(input logic signed [47:0] v);
        logic [23:0] r;
        if (v > 48'sd8388607)
            r = 24'h7FFFFF;
        else if (v < -48'sd8388608)
            r = 24'h800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

>>> rtl/core/synchronized_trapezoid_move_planner_top.sv
// Top level of the synchronized slide/pan/tilt trapezoid move planner.
// One command is taken at a time. A command that moves no axis, or arrives with a zero speed
// fraction, goes from mapping straight to the output step. For a command that moves an axis,
// every moving axis has its own lane with a bit-serial divider and a square root unit, the
// lanes run side by side, first to find each axis's move time (two divisions, or one division
// and a root) and then, after the longest time is picked, to re-solve accel and top speed (up
// to three divisions and a root). The result sits in an output register, so the next command
// is taken while it waits to be transferred.
module synchronized_trapezoid_move_planner_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  smp_pkg::smp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output smp_pkg::smp_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import smp_pkg::*;

    localparam logic [3:0] C_IDLE  = 4'd0;
    localparam logic [3:0] C_MAP1  = 4'd1;
    localparam logic [3:0] C_MAP2  = 4'd2;
    localparam logic [3:0] C_MAP3  = 4'd3;
    localparam logic [3:0] C_MAP4  = 4'd4;
    localparam logic [3:0] C_TGO   = 4'd5;
    localparam logic [3:0] C_TWAIT = 4'd6;
    localparam logic [3:0] C_MERGE = 4'd7;
    localparam logic [3:0] C_SGO   = 4'd8;
    localparam logic [3:0] C_SWAIT = 4'd9;
    localparam logic [3:0] C_OUT   = 4'd10;

    // configuration
    logic [15:0]        speed_frac_reg;
    logic [15:0]        accel_frac_reg;
    logic signed [23:0] slide_min_reg;
    logic signed [23:0] slide_max_reg;
    logic signed [23:0] pan_center_reg;
    logic signed [23:0] tilt_center_reg;

    // control
    logic [3:0]  state_reg, state_next;
    logic [2:0]  lane_done_reg, lane_done_next;
    logic        synced_reg, synced_next;
    logic        out_valid_reg, out_valid_next;
    logic        changed_reg;
    logic [2:0]  moving_reg;

    // datapath
    logic signed [15:0] rs_reg, rp_reg, rt_reg;
    logic signed [42:0] sl_prod_reg;
    logic [23:0]        pan_abs_reg;
    logic               pan_neg_reg;
    logic [24:0]        tilt_abs_reg;
    logic               tilt_neg_reg;
    logic [24:0]        spd_x0_reg;
    logic [26:0]        spd_x5_reg;
    logic [24:0]        acc_x0_reg;
    logic [28:0]        acc_x5_reg;
    logic signed [43:0] sl_sum_reg;
    logic [12:0]        pan_q_reg;
    logic [12:0]        tilt_q_reg;
    logic [15:0]        spd_base_reg [NUM_AXES];
    logic [16:0]        acc_base_reg [NUM_AXES];
    logic signed [23:0] tgt_reg [NUM_AXES];
    logic signed [23:0] last_reg [NUM_AXES];
    logic [24:0]        steps_reg [NUM_AXES];
    logic [31:0]        tmax_reg;
    smp_out_t           out_reg;

    logic               cfg_wr;
    logic signed [42:0] sl_u43, sl_d43;
    logic signed [24:0] sl_diff;
    logic signed [24:0] pan_x;
    logic signed [25:0] tilt_x;
    logic signed [43:0] slide_adj;
    logic signed [25:0] pan_sq, pan_sum;
    logic signed [25:0] tilt_sq, tilt_sum;
    logic signed [24:0] step_diff [NUM_AXES];
    logic [2:0]         moving_now;
    logic [31:0]        tmax_next;
    logic [31:0]        t_masked [NUM_AXES];
    lane_ctl_t          lane_ctl [NUM_AXES];
    lane_sts_t          lane_sts [NUM_AXES];
    logic [2:0]         lane_done_vec;
    smp_out_t           out_next;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_frac_reg  <= '0;
            accel_frac_reg  <= '0;
            slide_min_reg   <= 24'sh800000;
            slide_max_reg   <= 24'sh7FFFFF;
            pan_center_reg  <= '0;
            tilt_center_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_SPEED_FRAC:  speed_frac_reg  <= pwdata[15:0];
                REG_ACCEL_FRAC:  accel_frac_reg  <= pwdata[15:0];
                REG_SLIDE_MIN:   slide_min_reg   <= pwdata[23:0];
                REG_SLIDE_MAX:   slide_max_reg   <= pwdata[23:0];
                REG_PAN_CENTER:  pan_center_reg  <= pwdata[23:0];
                REG_TILT_CENTER: tilt_center_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SPEED_FRAC:  prdata = {16'd0, speed_frac_reg};
            REG_ACCEL_FRAC:  prdata = {16'd0, accel_frac_reg};
            REG_SLIDE_MIN:   prdata = {{8{slide_min_reg[23]}}, slide_min_reg};
            REG_SLIDE_MAX:   prdata = {{8{slide_max_reg[23]}}, slide_max_reg};
            REG_PAN_CENTER:  prdata = {{8{pan_center_reg[23]}}, pan_center_reg};
            REG_TILT_CENTER: prdata = {{8{tilt_center_reg[23]}}, tilt_center_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- target and base rate mapping ----------------
    // slide offset (r + 32768) as an unsigned 16-bit value
    assign sl_u43  = $signed({27'd0, ~rs_reg[15], rs_reg[14:0]});
    assign sl_diff = $signed({slide_max_reg[23], slide_max_reg})
                   - $signed({slide_min_reg[23], slide_min_reg});
    assign sl_d43  = $signed({{18{sl_diff[24]}}, sl_diff});
    assign pan_x   = $signed({{9{rp_reg[15]}}, rp_reg}) * 25'sd225;
    assign tilt_x  = $signed({{10{rt_reg[15]}}, rt_reg}) * 26'sd675 - 26'sd7372800;

    // division by 65536 truncating toward zero
    assign slide_adj = sl_sum_reg + (sl_sum_reg[43] ? 44'sd65535 : 44'sd0);
    assign pan_sq    = pan_neg_reg ? -$signed({13'd0, pan_q_reg}) : $signed({13'd0, pan_q_reg});
    assign pan_sum   = pan_sq + $signed({{2{pan_center_reg[23]}}, pan_center_reg});
    assign tilt_sq   = tilt_neg_reg ? -$signed({13'd0, tilt_q_reg})
                                    : $signed({13'd0, tilt_q_reg});
    assign tilt_sum  = tilt_sq + $signed({{2{tilt_center_reg[23]}}, tilt_center_reg});

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rs_reg <= in_data.slide_frac;
            rp_reg <= in_data.pan_frac;
            rt_reg <= in_data.tilt_frac;
        end
        if (state_reg == C_MAP1)
        begin
            sl_prod_reg  <= sl_u43 * sl_d43;
            pan_abs_reg  <= pan_x[24] ? 24'(-pan_x) : pan_x[23:0];
            pan_neg_reg  <= pan_x[24];
            tilt_abs_reg <= tilt_x[25] ? 25'(-tilt_x) : tilt_x[24:0];
            tilt_neg_reg <= tilt_x[25];
            spd_x0_reg   <= 25'd327680 + {9'd0, speed_frac_reg} * 25'd295;
            spd_x5_reg   <= 27'd1638400 + {11'd0, speed_frac_reg} * 27'd1225;
            acc_x0_reg   <= 25'd655360 + {9'd0, accel_frac_reg} * 25'd340;
            acc_x5_reg   <= 29'd32768000 + {13'd0, accel_frac_reg} * 29'd7000;
        end
        if (state_reg == C_MAP2)
        begin
            sl_sum_reg      <= $signed({sl_prod_reg[42], sl_prod_reg})
                             + $signed({{4{slide_min_reg[23]}}, slide_min_reg, 16'd0});
            pan_q_reg       <= 13'(({40'd0, pan_abs_reg} * RECIP_PAN) >> 38);
            tilt_q_reg      <= 13'(({39'd0, tilt_abs_reg} * RECIP_TILT) >> 40);
            spd_base_reg[0] <= 16'(({39'd0, spd_x0_reg} * SLIDE_K) >> 32);
            spd_base_reg[1] <= 16'(({37'd0, spd_x5_reg} * RECIP_SPD_PAN) >> 42);
            spd_base_reg[2] <= 16'(({37'd0, spd_x5_reg} * RECIP_SPD_TILT) >> 42);
            acc_base_reg[0] <= 17'(({39'd0, acc_x0_reg} * SLIDE_K) >> 32);
            acc_base_reg[1] <= 17'(({35'd0, acc_x5_reg} * RECIP_ACC_PAN) >> 44);
            acc_base_reg[2] <= 17'(({35'd0, acc_x5_reg} * RECIP_ACC_TILT) >> 44);
        end
        if (state_reg == C_MAP3)
        begin
            tgt_reg[0] <= sat24({{20{slide_adj[43]}}, slide_adj[43:16]});
            tgt_reg[1] <= sat24({{22{pan_sum[25]}}, pan_sum});
            tgt_reg[2] <= sat24({{22{tilt_sum[25]}}, tilt_sum});
            // zero speed fraction stops all axes
            if (speed_frac_reg == 16'd0)
            begin
                spd_base_reg[0] <= '0;
                spd_base_reg[1] <= '0;
                spd_base_reg[2] <= '0;
            end
        end
        if (state_reg == C_MERGE)
            tmax_reg <= tmax_next;
        if (state_reg == C_OUT && (!out_valid_reg || !out_stall))
            out_reg <= out_next;
    end

    // ---------------- steps, stored targets ----------------
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            step_diff[i]  = $signed({tgt_reg[i][23], tgt_reg[i]})
                          - $signed({last_reg[i][23], last_reg[i]});
            moving_now[i] = (step_diff[i] != 25'sd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                last_reg[i] <= '0;
            moving_reg  <= '0;
            changed_reg <= 1'b0;
        end
        else if (state_reg == C_MAP4)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                last_reg[i] <= tgt_reg[i];
            moving_reg  <= moving_now;
            changed_reg <= |moving_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_MAP4)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                steps_reg[i] <= step_diff[i][24] ? 25'(-step_diff[i]) : step_diff[i];
        end
    end

    // ---------------- lanes ----------------
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        assign lane_ctl[g].go_time = (state_reg == C_TGO) && moving_reg[g];
        assign lane_ctl[g].go_sync = (state_reg == C_SGO) && moving_reg[g];
        assign lane_done_vec[g]    = lane_sts[g].done;
        assign t_masked[g]         = moving_reg[g] ? lane_sts[g].move_time : 32'd0;

        smp_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl[g]),
            .speed_base (spd_base_reg[g]),
            .accel_base (acc_base_reg[g]),
            .steps      (steps_reg[g]),
            .tq         (tmax_reg),
            .sts        (lane_sts[g])
        );
    end

    // merge: longest move time over moving axes
    always_comb
    begin
        tmax_next = t_masked[0];
        if (t_masked[1] > tmax_next)
            tmax_next = t_masked[1];
        if (t_masked[2] > tmax_next)
            tmax_next = t_masked[2];
    end

    always_comb
    begin
        out_next.slide_target = tgt_reg[0];
        out_next.pan_target   = tgt_reg[1];
        out_next.tilt_target  = tgt_reg[2];
        out_next.move_changed = changed_reg;
        out_next.slide_speed  = (synced_reg && moving_reg[0]) ? lane_sts[0].speed
                                                              : spd_base_reg[0];
        out_next.pan_speed    = (synced_reg && moving_reg[1]) ? lane_sts[1].speed
                                                              : spd_base_reg[1];
        out_next.tilt_speed   = (synced_reg && moving_reg[2]) ? lane_sts[2].speed
                                                              : spd_base_reg[2];
        out_next.slide_accel  = (synced_reg && moving_reg[0]) ? lane_sts[0].accel
                                                              : acc_base_reg[0];
        out_next.pan_accel    = (synced_reg && moving_reg[1]) ? lane_sts[1].accel
                                                              : acc_base_reg[1];
        out_next.tilt_accel   = (synced_reg && moving_reg[2]) ? lane_sts[2].accel
                                                              : acc_base_reg[2];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        lane_done_next = lane_done_reg;
        synced_next    = synced_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            C_IDLE:
                if (in_valid)
                    state_next = C_MAP1;
            C_MAP1:
            begin
                synced_next = 1'b0;
                state_next  = C_MAP2;
            end
            C_MAP2: state_next = C_MAP3;
            C_MAP3: state_next = C_MAP4;
            C_MAP4:
                state_next = ((|moving_now) && (speed_frac_reg != 16'd0)) ? C_TGO : C_OUT;
            C_TGO:
            begin
                lane_done_next = ~moving_reg;
                state_next     = C_TWAIT;
            end
            C_TWAIT:
            begin
                lane_done_next = lane_done_reg | lane_done_vec;
                if (&lane_done_next)
                    state_next = C_MERGE;
            end
            C_MERGE:
                state_next = (tmax_next != 32'd0) ? C_SGO : C_OUT;
            C_SGO:
            begin
                lane_done_next = ~moving_reg;
                synced_next    = 1'b1;
                state_next     = C_SWAIT;
            end
            C_SWAIT:
            begin
                lane_done_next = lane_done_reg | lane_done_vec;
                if (&lane_done_next)
                    state_next = C_OUT;
            end
            C_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            lane_done_reg <= '0;
            synced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_done_reg <= lane_done_next;
            synced_reg    <= synced_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != C_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- assertions ----------------
    a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == C_MAP1)
        else $error("transfer in did not start mapping");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == C_OUT)
        else $error("result appeared outside the output step");

    a_lane_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done_vec) |-> (state_reg == C_TWAIT || state_reg == C_SWAIT))
        else $error("lane finished while sequencer was not waiting");

    a_sync_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_SGO |-> (|moving_reg) && tmax_reg != 32'd0)
        else $error("sync started without a moving axis");

endmodule

>>> rtl/core/smp_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module smp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quo
);
    import smp_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] q_reg;
    logic [31:0] den_reg;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, q_reg[63]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

>>> rtl/core/smp_sqrt.sv
// Integer square root of a 64-bit value, one root bit per cycle.
module smp_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);
    import smp_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[32:0], x_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], ge};
            x_reg    <= {x_reg[61:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/core/smp_lane.sv
// One axis lane: trapezoid move time, then accel and top speed for a common move time.
module smp_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smp_pkg::lane_ctl_t    ctl,
    input  logic [15:0]           speed_base,
    input  logic [16:0]           accel_base,
    input  logic [24:0]           steps,
    input  logic [31:0]           tq,
    output smp_pkg::lane_sts_t    sts
);
    import smp_pkg::*;

    localparam logic [3:0] L_IDLE = 4'd0;
    localparam logic [3:0] L_TMUL = 4'd1;
    localparam logic [3:0] L_TCMP = 4'd2;
    localparam logic [3:0] L_TDA  = 4'd3;
    localparam logic [3:0] L_TDB  = 4'd4;
    localparam logic [3:0] L_TDC  = 4'd5;
    localparam logic [3:0] L_TSQ  = 4'd6;
    localparam logic [3:0] L_SD1  = 4'd7;
    localparam logic [3:0] L_SD2  = 4'd8;
    localparam logic [3:0] L_SD3  = 4'd9;
    localparam logic [3:0] L_SSQ  = 4'd10;
    localparam logic [3:0] L_SMUL = 4'd11;
    localparam logic [3:0] L_SDE  = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        done_reg, done_next;
    logic [31:0] p0_reg, p0_next;
    logic [41:0] p1_reg, p1_next;
    logic [63:0] work_reg, work_next;
    logic [63:0] sq_reg, sq_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] spd_reg, spd_next;
    logic [16:0] acc_reg, acc_next;

    logic        op_div, op_sqrt;
    logic        div_done, sq_done;
    logic [63:0] div_num, div_quo;
    logic [31:0] div_den;
    logic [63:0] sq_rad;
    logic [31:0] sq_root;
    logic [63:0] tsum;
    logic [32:0] t2;
    logic [31:0] tdiff;
    logic [63:0] vprod;

    smp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (op_div && !issued_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    smp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (op_sqrt && !issued_reg),
        .rad   (sq_rad),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        op_div  = 1'b0;
        op_sqrt = 1'b0;
        div_num = work_reg;
        div_den = tq;
        sq_rad  = work_reg;
        case (state_reg)
            L_TDA:
            begin
                op_div  = 1'b1;
                div_num = {32'd0, speed_base, 16'd0};
                div_den = {15'd0, accel_base};
            end
            L_TDB:
            begin
                op_div  = 1'b1;
                div_num = {23'd0, steps, 16'd0};
                div_den = {16'd0, speed_base};
            end
            L_TDC:
            begin
                op_div  = 1'b1;
                div_num = {7'd0, steps, 32'd0};
                div_den = {15'd0, accel_base};
            end
            L_TSQ: op_sqrt = 1'b1;
            L_SD1:
            begin
                op_div  = 1'b1;
                div_num = {5'd0, steps, 34'd0};
            end
            L_SD2: op_div = 1'b1;
            L_SD3:
            begin
                op_div  = 1'b1;
                div_num = {5'd0, steps, 34'd0};
                div_den = {15'd0, accel_base};
            end
            L_SSQ:
            begin
                op_sqrt = 1'b1;
                sq_rad  = (sq_reg > work_reg) ? (sq_reg - work_reg) : 64'd0;
            end
            L_SDE:
            begin
                op_div  = 1'b1;
                div_num = {22'd0, steps, 17'd0};
            end
            default: ;
        endcase
    end

    assign tsum  = work_reg + div_quo;
    assign t2    = {sq_root, 1'b0};
    assign tdiff = tq - sq_root;
    assign vprod = {47'd0, accel_base} * work_reg;

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg ? !(div_done || sq_done) : (op_div || op_sqrt);
        done_next   = 1'b0;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        work_next   = work_reg;
        sq_next     = sq_reg;
        time_next   = time_reg;
        spd_next    = spd_reg;
        acc_next    = acc_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (ctl.go_time)
                    state_next = L_TMUL;
                else if (ctl.go_sync)
                begin
                    state_next = L_SD1;
                    sq_next    = {32'd0, tq} * {32'd0, tq};
                end
            end
            L_TMUL:
            begin
                p0_next    = {16'd0, speed_base} * {16'd0, speed_base};
                p1_next    = {25'd0, accel_base} * {17'd0, steps};
                state_next = L_TCMP;
            end
            L_TCMP:
                state_next = ({10'd0, p0_reg} <= p1_reg) ? L_TDA : L_TDC;
            L_TDA:
            begin
                if (div_done)
                begin
                    work_next  = div_quo;
                    state_next = L_TDB;
                end
            end
            L_TDB:
            begin
                if (div_done)
                begin
                    time_next  = (|tsum[63:32]) ? TIME_MAX : tsum[31:0];
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            L_TDC:
            begin
                if (div_done)
                begin
                    work_next  = div_quo;
                    state_next = L_TSQ;
                end
            end
            L_TSQ:
            begin
                if (sq_done)
                begin
                    time_next  = t2[32] ? TIME_MAX : t2[31:0];
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            L_SD1:
            begin
                if (div_done)
                begin
                    work_next  = div_quo;
                    state_next = L_SD2;
                end
            end
            L_SD2:
            begin
                // div_quo is the accel that fits the move time with no cruise
                if (div_done)
                begin
                    if ({47'd0, accel_base} > div_quo)
                    begin
                        acc_next   = accel_base;
                        state_next = L_SD3;
                    end
                    else
                    begin
                        acc_next   = (div_quo > {47'd0, ACCEL_MAX}) ? ACCEL_MAX
                                                                    : div_quo[16:0];
                        state_next = L_SDE;
                    end
                end
            end
            L_SD3:
            begin
                if (div_done)
                begin
                    work_next  = div_quo;
                    state_next = L_SSQ;
                end
            end
            L_SSQ:
            begin
                if (sq_done)
                begin
                    work_next  = {33'd0, tdiff[31:1]};
                    state_next = L_SMUL;
                end
            end
            L_SMUL:
            begin
                spd_next   = (|vprod[63:32]) ? SPEED_MAX : vprod[31:16];
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            L_SDE:
            begin
                if (div_done)
                begin
                    spd_next   = (|div_quo[63:16]) ? SPEED_MAX : div_quo[15:0];
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= L_IDLE;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        work_reg <= work_next;
        sq_reg   <= sq_next;
        time_reg <= time_next;
        spd_reg  <= spd_next;
        acc_reg  <= acc_next;
    end

    assign sts.done      = done_reg;
    assign sts.move_time = time_reg;
    assign sts.speed     = spd_reg;
    assign sts.accel     = acc_reg;

endmodule
